// ----- hdl/hcs_pkg.sv -----
// ----------------------------------------------------------------------------
// HTML comment stripper package
// Shared beat types and the byte constants of the comment delimiters.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam logic [7:0] ChLt   = 8'h3C;
    localparam logic [7:0] ChBang = 8'h21;
    localparam logic [7:0] ChDash = 8'h2D;
    localparam logic [7:0] ChGt   = 8'h3E;

    localparam int unsigned MaxBeats = 4;
    localparam logic [1:0]  PrefixLen = 2'd3;
    localparam logic [1:0]  DashLimit = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } t_out_beat;

    function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = ChLt;
            2'd1:    b = ChBang;
            2'd2:    b = ChDash;
            default: b = ChDash;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/hcs_stream_if.sv -----
// ----------------------------------------------------------------------------
// HTML comment stripper stream interface
// Valid/ready channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface hcs_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/html_comment_stripper_core.sv -----
// ----------------------------------------------------------------------------
// HTML comment stripper core
// Removes everything from an opening "<!--" through the closing "-->" in a
// byte stream, holding back partial openings until they resolve.
//
//   Channel  Direction  Payload                                Transfer
//   i_in     sink       in_byte, end_of_stream                 valid & ready
//   o_out    source     out_byte, last_of_run, stream_done     valid & ready
//
// Each input beat is decoded into zero to four output beats, which are
// loaded into a four-entry shift buffer and sent one per cycle while o_out is
// ready. A beat yielding at most one output is accepted every cycle while
// o_out is ready; one that releases held prefix bytes blocks input until its
// last output leaves. Input is accepted while the buffer is empty or its last
// beat leaves. Synchronous reset clears the matcher state and buffer count.
// ----------------------------------------------------------------------------
module html_comment_stripper_core
    import hcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    hcs_stream_if.sink          i_in,
    hcs_stream_if.source        o_out
);

    logic [1:0] r_pm, n_pm;
    logic       r_inside, n_inside;
    logic [1:0] r_dash, n_dash;
    logic [2:0] r_cnt;
    logic       r_last;
    logic [7:0] r_buf [MaxBeats];
    logic [7:0] n_buf [MaxBeats];

    logic       in_acc;
    logic       out_pop;
    logic [7:0] c;
    logic       eos;
    logic [1:0] held;
    logic       emit_c;
    logic [2:0] n_cnt;

    assign c       = i_in.payload.in_byte;
    assign eos     = i_in.payload.end_of_stream;
    assign out_pop = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);
    assign in_acc  = i_in.valid && i_in.ready;

    always_comb begin
        n_pm     = r_pm;
        n_inside = r_inside;
        n_dash   = r_dash;
        held     = 2'd0;
        emit_c   = 1'b0;
        if (r_inside) begin
            if ((c == ChGt) && (r_dash == DashLimit)) begin
                n_inside = 1'b0;
                n_dash   = 2'd0;
            end else if (c == ChDash) begin
                n_dash = (r_dash == DashLimit) ? DashLimit : r_dash + 2'd1;
            end else begin
                n_dash = 2'd0;
            end
        end else if ((r_pm == PrefixLen) && (c == ChDash)) begin
            n_pm     = 2'd0;
            n_inside = 1'b1;
            n_dash   = 2'd0;
        end else if ((r_pm != PrefixLen) && (c == prefix_byte(r_pm))) begin
            n_pm = r_pm + 2'd1;
            if (eos) begin
                held   = r_pm;
                emit_c = 1'b1;
            end
        end else begin
            held   = r_pm;
            emit_c = (c != ChLt) || eos;
            n_pm   = (c == ChLt) ? 2'd1 : 2'd0;
        end
        if (eos) begin
            n_pm     = 2'd0;
            n_inside = 1'b0;
            n_dash   = 2'd0;
        end
    end

    assign n_cnt = {1'b0, held} + {2'b00, emit_c};

    always_comb begin
        for (int i = 0; i < MaxBeats; i++) begin
            n_buf[i] = (3'(i) < {1'b0, held}) ? prefix_byte(2'(i)) : c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm     <= 2'd0;
            r_inside <= 1'b0;
            r_dash   <= 2'd0;
            r_cnt    <= 3'd0;
            r_last   <= 1'b0;
        end else if (in_acc) begin
            r_pm     <= n_pm;
            r_inside <= n_inside;
            r_dash   <= n_dash;
            r_cnt    <= n_cnt;
            r_last   <= eos;
        end else if (out_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf <= n_buf;
        end else if (out_pop) begin
            for (int i = 0; i < MaxBeats - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    assign o_out.valid               = (r_cnt != 3'd0);
    assign o_out.payload.out_byte    = r_buf[0];
    assign o_out.payload.last_of_run = (r_cnt == 3'd1);
    assign o_out.payload.stream_done = (r_cnt == 3'd1) && r_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(MaxBeats))
        else $error("output buffer count out of range");

    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_cnt == 3'd0) || ((r_cnt == 3'd1) && out_pop))
        else $error("input accepted while output beats still pending");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && eos) |=> (r_pm == 2'd0) && !r_inside && (r_dash == 2'd0))
        else $error("matcher state not cleared after end of stream");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.stream_done) |-> o_out.payload.last_of_run)
        else $error("stream_done without last_of_run");

    a_prefix_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> (r_pm == 2'd0))
        else $error("prefix held while inside a comment");

endmodule
